FILE: rtl/integer_to_ascii_formatter_core_defines.svh
// ----------------------------------------------------------------------------
// integer to ascii formatter assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define I2A_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2a check failed");

// next-cycle implication, sampled on clk, off during reset
`define I2A_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2a check failed");

`endif

FILE: rtl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a package
// mode codes, character constants and helpers for the ascii formatter
// ----------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

    localparam int VALUE_BITS_DEF = 32;

    localparam logic [2:0] MODE_SDEC  = 3'd0;
    localparam logic [2:0] MODE_UDEC  = 3'd1;
    localparam logic [2:0] MODE_HEXLO = 3'd2;
    localparam logic [2:0] MODE_HEXUP = 3'd3;
    localparam logic [2:0] MODE_CHAR  = 3'd4;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_LOWA  = 8'h61;
    localparam logic [7:0] ASCII_UPA   = 8'h41;
    localparam logic [7:0] ASCII_MINUS = 8'h2d;

    // control for the row of digit cells
    typedef struct packed {
        logic clear;
        logic shift_bit;
        logic shift_digit;
        logic dec;
    } cell_ctrl_t;

    // decimal digits needed for an unsigned word of b bits (1233/4096 ~ log10 2)
    function automatic int dec_digits(input int b);
        return ((b * 1233) >>> 12) + 1;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] d8;
        d8 = {4'h0, d};
        if (d < 4'd10)
        begin
            return ASCII_ZERO + d8;
        end
        else if (upper)
        begin
            return ASCII_UPA + d8 - 8'd10;
        end
        else
        begin
            return ASCII_LOWA + d8 - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer to ascii formatter core
// prints a value as decimal, hex or a single character, one item per char
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall carry value and mode; one item is taken
//   while the core is idle, and in_stall stays high until its last character
//   has been loaded into the output register
// output channel: out_valid / out_stall carry ascii_char and last, most
//   significant character first, last set on the final character
// numeric modes: a load state that clears the row of digit cells, a bit
//   shift through the cells for each of the VALUE_BITS value bits, then one
//   step per digit cell (dec_digits of VALUE_BITS, 10 at 32 bits) plus one
//   for a minus sign; leading zero cells are stepped over without output
// char mode: the low byte of value is registered, then presented as the only character
// unused mode codes are taken and produce nothing
// a stalled receiver freezes the character sequence; the output register
//   holds its item until taken
// reset empties the output register and returns to idle
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_formatter_core
#(
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire [VALUE_BITS-1:0] value,
    input  wire [2:0]            mode,
    output logic                 out_valid,
    input  wire                  out_stall,
    output logic [7:0]           ascii_char,
    output logic                 last
);
    import i2a_pkg::*;

    localparam int NUM_DIGITS = dec_digits(VALUE_BITS);
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int REM_W      = $clog2(NUM_DIGITS + 1);

    typedef enum logic [4:0]
    {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_EMIT = 5'b00100,
        ST_CHR  = 5'b01000,
        ST_LOAD = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic              neg_reg, neg_next;
    logic              dec_reg, dec_next;
    logic              upper_reg, upper_next;
    logic              started_reg, started_next;
    logic [7:0]        chr_reg, chr_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    cell_ctrl_t        ctrl;
    logic [NUM_DIGITS-1:0] carry;
    logic [3:0]        digits [NUM_DIGITS];
    logic [3:0]        top_digit;
    logic              accept;
    logic              slot_free;
    logic              in_neg;

    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign slot_free  = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign ascii_char = out_char_reg;
    assign last       = out_last_reg;
    assign top_digit  = digits[NUM_DIGITS-1];
    assign in_neg     = (mode == MODE_SDEC) && value[VALUE_BITS-1];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_DIGITS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                i2a_digit_cell u_cell
                (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (ctrl),
                    .bit_in   (mag_reg[VALUE_BITS-1]),
                    .digit_in (4'd0),
                    .bit_out  (carry[gi]),
                    .digit    (digits[gi])
                );
            end
            else
            begin : g_rest
                i2a_digit_cell u_cell
                (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (ctrl),
                    .bit_in   (carry[gi-1]),
                    .digit_in (digits[gi-1]),
                    .bit_out  (carry[gi]),
                    .digit    (digits[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        dec_next       = dec_reg;
        upper_next     = upper_reg;
        started_next   = started_reg;
        chr_next       = chr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        ctrl           = '{clear: 1'b0, shift_bit: 1'b0, shift_digit: 1'b0, dec: dec_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mag_next     = in_neg ? (~value + 1'b1) : value;
                    neg_next     = in_neg;
                    dec_next     = (mode == MODE_SDEC) || (mode == MODE_UDEC);
                    upper_next   = (mode == MODE_HEXUP);
                    chr_next     = value[7:0];
                    cnt_next     = CNT_W'(VALUE_BITS);
                    rem_next     = REM_W'(NUM_DIGITS);
                    started_next = 1'b0;
                    if (mode == MODE_CHAR)
                    begin
                        state_next = ST_CHR;
                    end
                    else if (mode < MODE_CHAR)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                ctrl.clear = 1'b1;
                state_next = ST_CONV;
            end
            ST_CONV:
            begin
                ctrl.shift_bit = 1'b1;
                mag_next       = {mag_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next       = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (neg_reg)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = ASCII_MINUS;
                        out_last_next  = 1'b0;
                        neg_next       = 1'b0;
                    end
                end
                else if (!started_reg && (top_digit == 4'd0) && (rem_reg != REM_W'(1)))
                begin
                    // leading zero: step past it
                    ctrl.shift_digit = 1'b1;
                    rem_next         = rem_reg - 1'b1;
                end
                else if (slot_free)
                begin
                    ctrl.shift_digit = 1'b1;
                    rem_next         = rem_reg - 1'b1;
                    started_next     = 1'b1;
                    out_valid_next   = 1'b1;
                    out_char_next    = digit_char(top_digit, upper_reg);
                    out_last_next    = (rem_reg == REM_W'(1));
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CHR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = chr_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            neg_reg       <= 1'b0;
            started_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            neg_reg       <= neg_next;
            started_reg   <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        dec_reg      <= dec_next;
        upper_reg    <= upper_next;
        chr_reg      <= chr_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

FILE: rtl/i2a_digit_cell.sv
// ----------------------------------------------------------------------------
// i2a digit cell
// one 4-bit digit: double-dabble shift with add-3 correction, or digit shift
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_digit_cell
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  i2a_pkg::cell_ctrl_t ctrl,
    input  wire                 bit_in,
    input  wire  [3:0]          digit_in,
    output logic                bit_out,
    output logic [3:0]          digit
);
    import i2a_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // add 3 before the shift keeps the digit decimal; hex shifts plain
    assign adj     = (ctrl.dec && (digit_reg >= 4'd5)) ? digit_reg + 4'd3 : digit_reg;
    assign bit_out = adj[3];
    assign digit   = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.shift_bit)
        begin
            digit_next = {adj[2:0], bit_in};
        end
        else if (ctrl.shift_digit)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= 4'd0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/i2a_checker.sv
// ----------------------------------------------------------------------------
// i2a checker
// port-level checks on the ascii formatter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_to_ascii_formatter_core_defines.svh"

module i2a_checker
#(
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
)
(
    input wire                  clk,
    input wire                  rst_n,
    input wire                  in_valid,
    input wire                  in_stall,
    input wire [VALUE_BITS-1:0] value,
    input wire [2:0]            mode,
    input wire                  out_valid,
    input wire                  out_stall,
    input wire [7:0]            ascii_char,
    input wire                  last
);
    import i2a_pkg::*;

    logic took_real;
    assign took_real = in_valid && !in_stall && (mode <= MODE_CHAR) && (value == value);

    // a stalled output item stays put
    `I2A_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `I2A_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(ascii_char) && $stable(last))

    // an item with output keeps the input closed in the next cycle
    `I2A_ASSERT_NEXT(a_busy_after_take, took_real, in_stall)

    // a conversion that has not ended keeps the input closed
    `I2A_ASSERT_NOW(a_busy_mid_item, out_valid && !last, in_stall)

endmodule

bind integer_to_ascii_formatter_core i2a_checker #(.VALUE_BITS(VALUE_BITS)) u_i2a_checker (.*);

`default_nettype wire

FILE: sim/integer_to_ascii_formatter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer to ascii formatter core testbench
// feeds values in every print mode through the core and checks each output
// character and its last flag against a predicted character stream, with
// bursty input traffic and a receiver that stalls in changing patterns
// ----------------------------------------------------------------------------

module integer_to_ascii_formatter_core_test;

    import i2a_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 270;
    localparam int DRAIN_CYCLES = 100;
    localparam int LONG_HOLD_CYCLES = 400;

    // mode codes the core takes but prints nothing for
    localparam logic [2:0] MODE_RSVD5 = 3'd5;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    localparam logic [127:0] LOWER_DIGITS = "0123456789abcdef";
    localparam logic [127:0] UPPER_DIGITS = "0123456789ABCDEF";

    typedef struct packed {
        logic [31:0] val;
        logic [2:0]  md;
        logic        drain;
    } pending_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
    } char_exp_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] value = 32'd0;
    logic [2:0]  mode = MODE_SDEC;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  ascii_char;
    logic        last;

    pending_item_t pending_items[$];
    char_exp_t     expected_chars[$];
    pending_item_t next_item;
    char_exp_t     want;

    int error_count = 0;
    int chars_checked = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int burst_left = 1;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    stall_style_t stall_style = STALL_NONE;

    integer_to_ascii_formatter_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .mode       (mode),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ascii_char (ascii_char),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic void expect_char(input logic [7:0] ch, input logic is_last);
        char_exp_t c;
        c.ch = ch;
        c.is_last = is_last;
        expected_chars.push_back(c);
    endfunction

    // characters the core should print for one item, most significant first
    function automatic void predict_chars(input logic [31:0] val, input logic [2:0] md);
        logic [7:0]   digit_buf [0:11];
        logic [31:0]  mag;
        logic [31:0]  radix;
        logic [31:0]  rem;
        logic [127:0] digit_set;
        int           n;
        bit           neg;
        mag = val;
        radix = 32'd10;
        digit_set = LOWER_DIGITS;
        neg = 1'b0;
        n = 0;
        case (md)
            MODE_SDEC:
            begin
                // most negative value negates to itself, which is its magnitude
                if (val[31])
                begin
                    neg = 1'b1;
                    mag = ~val + 32'd1;
                end
            end
            MODE_UDEC:
            begin
                radix = 32'd10;
            end
            MODE_HEXLO:
            begin
                radix = 32'd16;
            end
            MODE_HEXUP:
            begin
                radix = 32'd16;
                digit_set = UPPER_DIGITS;
            end
            MODE_CHAR:
            begin
                expect_char(val[7:0], 1'b1);
                return;
            end
            default:
            begin
                return;
            end
        endcase
        do
        begin
            rem = mag % radix;
            digit_buf[n] = digit_set[8 * (15 - rem[3:0]) +: 8];
            n++;
            mag = mag / radix;
        end
        while (mag != 32'd0);
        if (neg)
        begin
            expect_char(ASCII_MINUS, 1'b0);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            expect_char(digit_buf[i], i == 0);
        end
    endfunction

    task automatic queue_item(input logic [31:0] val, input logic [2:0] md, input logic drain);
        pending_item_t p;
        p.val = val;
        p.md = md;
        p.drain = drain;
        pending_items.push_back(p);
    endtask

    // values weighted towards digit count and sign boundaries
    function automatic logic [31:0] pick_value();
        logic [31:0] p;
        int          k;
        p = 32'd1;
        case ($urandom_range(0, 6))
            0: return $urandom;
            1: return $urandom_range(0, 20);
            2:
            begin
                k = $urandom_range(0, 9);
                repeat (k) p = p * 32'd10;
                return p + $urandom_range(0, 2) - 32'd1;
            end
            3:
            begin
                k = $urandom_range(0, 31);
                return (32'd1 << k) + $urandom_range(0, 2) - 32'd1;
            end
            4: return 32'd0 - $urandom_range(1, 1000);
            5: return 32'h8000_0000 + $urandom_range(0, 6) - 32'd3;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // driver: bursts of items with random gaps, one assignment per signal per edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_chars(value, mode);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0 &&
                         !(pending_items[0].drain && expected_chars.size() != 0))
                begin
                    next_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    value <= next_item.val;
                    mode <= next_item.md;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off once traffic is flowing
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && chars_checked >= 150)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (stall_left == 0)
                begin
                    stall_style = stall_style_t'($urandom_range(0, 3));
                    stall_left = $urandom_range(16, 96);
                end
                else
                begin
                    stall_left--;
                end
                case (stall_style)
                    STALL_NONE:   out_stall <= 1'b0;
                    STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 6);
                    default:      out_stall <= !out_stall;
                endcase
            end
        end
    end

    // monitor: every accepted character against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected char 0x%02h last %0b", ascii_char, last));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (ascii_char !== want.ch)
                begin
                    report_mismatch($sformatf("ascii_char 0x%02h, expected 0x%02h",
                                              ascii_char, want.ch));
                end
                if (last !== want.is_last)
                begin
                    report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
                                              last, want.is_last, want.ch));
                end
                chars_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          taken;
        logic [2:0]  md;
        // extremes in every mode
        queue_item(32'h0000_0000, MODE_SDEC, 1'b0);
        queue_item(32'h0000_0000, MODE_UDEC, 1'b0);
        queue_item(32'h0000_0000, MODE_HEXLO, 1'b0);
        queue_item(32'h0000_0000, MODE_HEXUP, 1'b0);
        queue_item(32'h0000_0000, MODE_CHAR, 1'b0);
        queue_item(32'hFFFF_FFFF, MODE_SDEC, 1'b0);
        queue_item(32'hFFFF_FFFF, MODE_UDEC, 1'b0);
        queue_item(32'hFFFF_FFFF, MODE_HEXLO, 1'b0);
        queue_item(32'hFFFF_FFFF, MODE_HEXUP, 1'b0);
        queue_item(32'hFFFF_FFFF, MODE_CHAR, 1'b0);
        // most negative signed value, then its neighbours
        queue_item(32'h8000_0000, MODE_SDEC, 1'b0);
        queue_item(32'h8000_0000, MODE_UDEC, 1'b0);
        queue_item(32'h7FFF_FFFF, MODE_SDEC, 1'b0);
        queue_item(32'h8000_0001, MODE_SDEC, 1'b0);
        queue_item(32'd9, MODE_UDEC, 1'b0);
        queue_item(32'd10, MODE_SDEC, 1'b0);
        queue_item(32'd15, MODE_HEXLO, 1'b0);
        queue_item(32'd16, MODE_HEXUP, 1'b0);
        queue_item(32'hDEAD_BEEF, MODE_HEXLO, 1'b0);
        queue_item(32'hCAFE_F00D, MODE_HEXUP, 1'b0);
        // char mode ignores the upper bytes
        queue_item(32'h1234_5641, MODE_CHAR, 1'b0);
        // unused mode codes print nothing
        queue_item(32'h0000_0007, MODE_RSVD5, 1'b0);
        queue_item(32'hFFFF_FFFF, 3'd6, 1'b0);
        queue_item(32'h8000_0000, MODE_RSVD7, 1'b0);
        queue_item(32'd1, MODE_SDEC, 1'b0);

        taken = 0;
        while (taken < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                md = 3'($urandom_range(MODE_RSVD5, MODE_RSVD7));
                queue_item($urandom, md, 1'b0);
            end
            else
            begin
                md = 3'($urandom_range(MODE_SDEC, MODE_CHAR));
                // sender waits for the core to drain before these two
                queue_item(pick_value(), md, taken == 0 || taken == RANDOM_ITEMS / 2);
                taken++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid || expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
